// ----- design/eight_bit_harvard_cpu_core_top_defines.svh -----
`ifndef EIGHT_BIT_HARVARD_CPU_CORE_TOP_DEFINES_SVH
`define EIGHT_BIT_HARVARD_CPU_CORE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define EBHCPU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ebhcpu: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define EBHCPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ebhcpu: next-cycle check failed");

`endif

// ----- design/ebhcpu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ebhcpu_pkg;

    localparam int RAM_ADDR_BITS = 15;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_AND    = 3'd1;
    localparam logic [2:0] OP_OR     = 3'd2;
    localparam logic [2:0] OP_XOR    = 3'd3;
    localparam logic [2:0] OP_ADD    = 3'd4;
    localparam logic [2:0] OP_SUB    = 3'd5;
    localparam logic [2:0] OP_STORE  = 3'd6;
    localparam logic [2:0] OP_BRANCH = 3'd7;

    localparam logic [2:0] MODE_AC_D   = 3'd0;
    localparam logic [2:0] MODE_AC_X   = 3'd1;
    localparam logic [2:0] MODE_AC_YD  = 3'd2;
    localparam logic [2:0] MODE_AC_YX  = 3'd3;
    localparam logic [2:0] MODE_X_D    = 3'd4;
    localparam logic [2:0] MODE_Y_D    = 3'd5;
    localparam logic [2:0] MODE_OUT_D  = 3'd6;
    localparam logic [2:0] MODE_OUT_YX = 3'd7;

    localparam logic [2:0] COND_JUMP = 3'd0;

    localparam logic [1:0] SRC_OPERAND = 2'd0;
    localparam logic [1:0] SRC_RAM     = 2'd1;
    localparam logic [1:0] SRC_AC      = 2'd2;
    localparam logic [1:0] SRC_PORT    = 2'd3;

    typedef struct packed {
        logic [7:0] instruction_byte;
        logic [7:0] operand_byte;
        logic [7:0] input_port;
        logic [7:0] floating_bus;
    } in_item_t;

    typedef struct packed {
        logic [15:0] fetch_address;
        logic [7:0]  output_port;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/ebhcpu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ebhcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/eight_bit_harvard_cpu_core_top.sv -----
// A transaction accepted into the execute stage registers has its result written to the
// output register when that stage fires. One transaction per cycle while the output
// does not stall; the data RAM read feeds the next read address through the ALU. A
// stalled result holds the execute stage, and input is taken again once it moves on.
// Reset (aresetn low, synchronous): registers and program counter go to zero, then all
// 2^RAM_ADDR_BITS (32768) data RAM locations are cleared with s_ready low.
`timescale 1ns / 1ps
`default_nettype none
`include "eight_bit_harvard_cpu_core_top_defines.svh"

module eight_bit_harvard_cpu_core_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ebhcpu_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ebhcpu_pkg::out_item_t      m_data
);

    import ebhcpu_pkg::*;

    localparam int AW = RAM_ADDR_BITS;

    // architectural state
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  ac_reg, ac_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  out_reg, out_next;
    logic [7:0]  lat_op_reg, lat_d_reg;

    // RAM clear sweep
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // execute stage
    logic          b_valid_reg;
    logic [7:0]    b_op_reg;
    logic [7:0]    b_d_reg;
    logic [7:0]    b_port_reg;
    logic [7:0]    b_float_reg;
    logic [AW-1:0] b_addr_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic          accept, b_fire;
    logic [7:0]    x_eff, y_eff;
    logic [2:0]    a_op, a_mode;
    logic [7:0]    a_lo, a_hi;
    logic [15:0]   a_addr16;
    logic [AW-1:0] rd_addr;

    logic [2:0] b_op, b_mode;
    logic [1:0] b_src;
    logic       b_store, b_branch;
    logic [7:0] ram_rdata, mem_rd, bus, alu;
    logic       wr_ac, wr_x, wr_y, wr_out, inc_x;
    logic [1:0] cond;
    logic       taken;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [47:0]   arch_state;

    assign b_fire  = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!b_valid_reg || b_fire);
    assign accept  = s_valid && s_ready;

    // X and Y as they stand after the instruction now in execute
    assign x_eff = b_fire ? x_next : x_reg;
    assign y_eff = b_fire ? y_next : y_reg;

    assign a_op   = lat_op_reg[7:5];
    assign a_mode = lat_op_reg[4:2];

    always_comb begin
        a_lo = lat_d_reg;
        a_hi = 8'h00;
        if (a_op != OP_BRANCH) begin
            case (a_mode)
                MODE_AC_X: a_lo = x_eff;
                MODE_AC_YD: a_hi = y_eff;
                MODE_AC_YX, MODE_OUT_YX: begin
                    a_lo = x_eff;
                    a_hi = y_eff;
                end
                default: begin
                    a_lo = lat_d_reg;
                    a_hi = 8'h00;
                end
            endcase
        end
    end

    assign a_addr16 = {a_hi, a_lo};
    assign rd_addr  = a_addr16[AW-1:0];

    // execute
    assign b_op     = b_op_reg[7:5];
    assign b_mode   = b_op_reg[4:2];
    assign b_src    = b_op_reg[1:0];
    assign b_store  = (b_op == OP_STORE);
    assign b_branch = (b_op == OP_BRANCH);
    assign mem_rd   = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb begin
        case (b_src)
            SRC_OPERAND: bus = b_d_reg;
            SRC_RAM:     bus = b_store ? b_float_reg : mem_rd;
            SRC_AC:      bus = ac_reg;
            SRC_PORT:    bus = b_port_reg;
            default:     bus = b_d_reg;
        endcase
    end

    always_comb begin
        case (b_op)
            OP_LOAD:  alu = bus;
            OP_AND:   alu = ac_reg & bus;
            OP_OR:    alu = ac_reg | bus;
            OP_XOR:   alu = ac_reg ^ bus;
            OP_ADD:   alu = ac_reg + bus;
            OP_SUB:   alu = ac_reg - bus;
            OP_STORE: alu = ac_reg;
            default:  alu = 8'h00 - ac_reg;
        endcase
    end

    always_comb begin
        wr_ac  = 1'b0;
        wr_x   = 1'b0;
        wr_y   = 1'b0;
        wr_out = 1'b0;
        inc_x  = 1'b0;
        if (!b_branch) begin
            case (b_mode)
                MODE_AC_D, MODE_AC_X, MODE_AC_YD, MODE_AC_YX: wr_ac = !b_store;
                MODE_X_D: wr_x = 1'b1;
                MODE_Y_D: wr_y = 1'b1;
                MODE_OUT_D: wr_out = !b_store;
                MODE_OUT_YX: begin
                    wr_out = !b_store;
                    inc_x  = 1'b1;
                end
                default: wr_ac = 1'b0;
            endcase
        end
    end

    assign cond  = {ac_reg == 8'h00, ac_reg[7]};
    assign taken = b_mode[cond];

    always_comb begin
        ac_next  = wr_ac ? alu : ac_reg;
        y_next   = wr_y ? alu : y_reg;
        out_next = wr_out ? alu : out_reg;
        x_next   = x_reg;
        if (wr_x) begin
            x_next = alu;
        end else if (inc_x) begin
            x_next = x_reg + 8'd1;
        end
        pc_next = pc_reg + 16'd1;
        if (b_branch) begin
            if (b_mode == COND_JUMP) begin
                pc_next = {y_reg, bus};
            end else if (taken) begin
                pc_next = {pc_reg[15:8], bus};
            end
        end
    end

    assign ram_we    = clearing_reg || (b_fire && b_store);
    assign ram_waddr = clearing_reg ? clr_addr_reg : b_addr_reg;
    assign ram_wdata = clearing_reg ? 8'h00 : bus;

    ebhcpu_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == {AW{1'b1}}) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_op_reg  <= 8'h00;
            lat_d_reg   <= 8'h00;
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (accept) begin
                lat_op_reg  <= s_data.instruction_byte;
                lat_d_reg   <= s_data.operand_byte;
                fwd_hit_reg <= b_fire && b_store && (b_addr_reg == rd_addr);
                b_valid_reg <= 1'b1;
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_op_reg     <= lat_op_reg;
            b_d_reg      <= lat_d_reg;
            b_port_reg   <= s_data.input_port;
            b_float_reg  <= s_data.floating_bus;
            b_addr_reg   <= rd_addr;
            fwd_data_reg <= bus;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= 16'h0000;
            ac_reg  <= 8'h00;
            x_reg   <= 8'h00;
            y_reg   <= 8'h00;
            out_reg <= 8'h00;
        end else if (b_fire) begin
            pc_reg  <= pc_next;
            ac_reg  <= ac_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_data_reg.fetch_address <= pc_next;
            m_data_reg.output_port   <= out_next;
            m_data_reg.accumulator   <= ac_next;
            m_data_reg.index_x       <= x_next;
            m_data_reg.index_y       <= y_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign arch_state = {pc_reg, ac_reg, x_reg, y_reg, out_reg};

    `EBHCPU_ASSERT_NOW(a_no_accept_clearing, clearing_reg, !s_ready)
    `EBHCPU_ASSERT_NOW(a_accept_frees_exec, accept && b_valid_reg, b_fire)
    `EBHCPU_ASSERT_NEXT(a_fire_gives_result, b_fire, m_valid)
    `EBHCPU_ASSERT_NEXT(a_state_holds, !b_fire, $stable(arch_state))
    `EBHCPU_ASSERT_NEXT(a_fwd_on_collision, ram_we && accept && (ram_waddr == rd_addr), fwd_hit_reg)

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ebhcpu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1880;
    localparam int PHASE_LEN = 634;

    localparam logic [2:0] COND_POS  = 3'd1;
    localparam logic [2:0] COND_NEG  = 3'd2;
    localparam logic [2:0] COND_ZERO = 3'd4;
    localparam logic [2:0] COND_ANY  = 3'd7;

    typedef enum {DST_NONE, DST_AC, DST_X, DST_Y, DST_OUT} dest_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    eight_bit_harvard_cpu_core_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted core state
    logic [15:0] pc_q = '0;
    logic [7:0]  op_latch = '0;
    logic [7:0]  d_latch = '0;
    logic [7:0]  ac_q = '0;
    logic [7:0]  x_q = '0;
    logic [7:0]  y_q = '0;
    logic [7:0]  out_q = '0;
    logic [7:0]  data_ram [RAM_DEPTH];

    in_item_t  fetch_queue[$];
    out_item_t expected_state[$];
    int        mismatch_count = 0;
    int        n_accepted = 0;
    int        cycles = 0;
    int        send_idle_pct;
    int        recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic execute_cycle(input in_item_t it, output out_item_t res);
        logic [2:0]  op;
        logic [2:0]  mode;
        logic [1:0]  src;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  bus;
        logic [7:0]  alu;
        logic [7:0]  old_ac;
        logic [15:0] nxt;
        int          ram_idx;
        int          cond;
        bit          is_store;
        bit          is_branch;
        bit          inc_x;
        dest_t       dest;
        op = op_latch[7:5];
        mode = op_latch[4:2];
        src = op_latch[1:0];
        is_store = (op == OP_STORE);
        is_branch = (op == OP_BRANCH);
        lo = d_latch;
        hi = 8'h00;
        dest = DST_NONE;
        inc_x = 1'b0;
        old_ac = ac_q;
        if (!is_branch) begin
            case (mode)
                MODE_AC_D: dest = DST_AC;
                MODE_AC_X: begin
                    dest = DST_AC;
                    lo = x_q;
                end
                MODE_AC_YD: begin
                    dest = DST_AC;
                    hi = y_q;
                end
                MODE_AC_YX: begin
                    dest = DST_AC;
                    lo = x_q;
                    hi = y_q;
                end
                MODE_X_D: dest = DST_X;
                MODE_Y_D: dest = DST_Y;
                MODE_OUT_D: dest = DST_OUT;
                default: begin
                    dest = DST_OUT;
                    lo = x_q;
                    hi = y_q;
                    inc_x = 1'b1;
                end
            endcase
            if (is_store && (dest == DST_AC || dest == DST_OUT))
                dest = DST_NONE;
        end
        ram_idx = {hi, lo} & (RAM_DEPTH - 1);
        case (src)
            SRC_OPERAND: bus = d_latch;
            SRC_RAM: bus = is_store ? it.floating_bus : data_ram[ram_idx];
            SRC_AC: bus = ac_q;
            default: bus = it.input_port;
        endcase
        if (is_store)
            data_ram[ram_idx] = bus;
        case (op)
            OP_LOAD: alu = bus;
            OP_AND: alu = ac_q & bus;
            OP_OR: alu = ac_q | bus;
            OP_XOR: alu = ac_q ^ bus;
            OP_ADD: alu = ac_q + bus;
            OP_SUB: alu = ac_q - bus;
            OP_STORE: alu = ac_q;
            default: alu = 8'h00 - ac_q;
        endcase
        case (dest)
            DST_AC: ac_q = alu;
            DST_X: x_q = alu;
            DST_Y: y_q = alu;
            DST_OUT: out_q = alu;
            default: ;
        endcase
        if (inc_x)
            x_q = x_q + 8'd1;
        nxt = pc_q + 16'd1;
        if (is_branch) begin
            if (mode == COND_JUMP) begin
                nxt = {y_q, bus};
            end else begin
                cond = old_ac[7] + ((old_ac == 8'h00) ? 2 : 0);
                if (mode[cond])
                    nxt = {pc_q[15:8], bus};
            end
        end
        pc_q = nxt;
        op_latch = it.instruction_byte;
        d_latch = it.operand_byte;
        res.fetch_address = pc_q;
        res.output_port = out_q;
        res.accumulator = ac_q;
        res.index_x = x_q;
        res.index_y = y_q;
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic queue_fetch(input logic [2:0] op, input logic [2:0] mode,
                               input logic [1:0] src, input logic [7:0] d,
                               input logic [7:0] port, input logic [7:0] flt);
        in_item_t it;
        it.instruction_byte = {op, mode, src};
        it.operand_byte = d;
        it.input_port = port;
        it.floating_bus = flt;
        fetch_queue.push_back(it);
    endtask

    always_comb begin
        if (n_accepted < PHASE_LEN) begin
            send_idle_pct = 36;
            recv_idle_pct = 54;
        end else if (n_accepted < 2 * PHASE_LEN) begin
            send_idle_pct = 54;
            recv_idle_pct = 36;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // driver
    always @(posedge aclk) begin
        out_item_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                execute_cycle(s_data, res);
                expected_state.push_back(res);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (fetch_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data <= fetch_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_state.size() == 0) begin
                report_mismatch("unexpected transaction", m_data.fetch_address, 16'h0000);
            end else begin
                want = expected_state.pop_front();
                if (m_data.fetch_address !== want.fetch_address)
                    report_mismatch("fetch_address", m_data.fetch_address, want.fetch_address);
                if (m_data.output_port !== want.output_port)
                    report_mismatch("output_port", 16'(m_data.output_port),
                                    16'(want.output_port));
                if (m_data.accumulator !== want.accumulator)
                    report_mismatch("accumulator", 16'(m_data.accumulator),
                                    16'(want.accumulator));
                if (m_data.index_x !== want.index_x)
                    report_mismatch("index_x", 16'(m_data.index_x), 16'(want.index_x));
                if (m_data.index_y !== want.index_y)
                    report_mismatch("index_y", 16'(m_data.index_y), 16'(want.index_y));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        foreach (data_ram[i])
            data_ram[i] = 8'h00;

        // extremes, wraparound, stores, delay-slot branches
        queue_fetch(OP_LOAD,   MODE_AC_D,   SRC_OPERAND, 8'hff, 8'h00, 8'h00);
        queue_fetch(OP_ADD,    MODE_AC_D,   SRC_OPERAND, 8'h01, 8'h00, 8'hff);
        queue_fetch(OP_SUB,    MODE_AC_D,   SRC_OPERAND, 8'h01, 8'h00, 8'h00);
        queue_fetch(OP_LOAD,   MODE_X_D,    SRC_PORT,    8'h00, 8'hff, 8'h00);
        queue_fetch(OP_LOAD,   MODE_Y_D,    SRC_OPERAND, 8'hff, 8'h00, 8'h00);
        queue_fetch(OP_STORE,  MODE_OUT_YX, SRC_AC,      8'h00, 8'h00, 8'h00);
        queue_fetch(OP_STORE,  MODE_AC_YX,  SRC_RAM,     8'h00, 8'h00, 8'ha5);
        queue_fetch(OP_LOAD,   MODE_AC_YD,  SRC_RAM,     8'h00, 8'h00, 8'h00);
        queue_fetch(OP_AND,    MODE_AC_X,   SRC_OPERAND, 8'h0f, 8'h00, 8'h00);
        queue_fetch(OP_OR,     MODE_OUT_D,  SRC_OPERAND, 8'hf0, 8'h00, 8'h00);
        queue_fetch(OP_XOR,    MODE_AC_D,   SRC_AC,      8'h00, 8'h00, 8'h00);
        queue_fetch(OP_STORE,  MODE_X_D,    SRC_OPERAND, 8'h33, 8'h00, 8'h00);
        queue_fetch(OP_STORE,  MODE_Y_D,    SRC_PORT,    8'h34, 8'hc3, 8'h00);
        queue_fetch(OP_LOAD,   MODE_AC_X,   SRC_RAM,     8'h00, 8'h00, 8'h00);
        queue_fetch(OP_BRANCH, COND_ZERO,   SRC_OPERAND, 8'h40, 8'h00, 8'h00);
        queue_fetch(OP_LOAD,   MODE_AC_D,   SRC_OPERAND, 8'h80, 8'h00, 8'h00);
        queue_fetch(OP_BRANCH, COND_NEG,    SRC_RAM,     8'h34, 8'h00, 8'h00);
        queue_fetch(OP_LOAD,   MODE_Y_D,    SRC_OPERAND, 8'hff, 8'h00, 8'h00);
        queue_fetch(OP_BRANCH, COND_POS,    SRC_OPERAND, 8'h10, 8'h00, 8'h00);
        queue_fetch(OP_BRANCH, COND_JUMP,   SRC_OPERAND, 8'hff, 8'h00, 8'h00);
        queue_fetch(OP_LOAD,   MODE_AC_D,   SRC_OPERAND, 8'h00, 8'h00, 8'h00);
        queue_fetch(OP_BRANCH, COND_ANY,    SRC_AC,      8'h00, 8'h00, 8'h00);
        queue_fetch(OP_LOAD,   MODE_AC_D,   SRC_OPERAND, 8'h7f, 8'h00, 8'h00);

        // small operands half the time so RAM reads land on written bytes
        repeat (RANDOM_ITEMS) begin
            it.instruction_byte = 8'($urandom_range(0, 255));
            it.operand_byte = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                          : 8'($urandom_range(0, 255));
            it.input_port = 8'($urandom_range(0, 255));
            it.floating_bus = 8'($urandom_range(0, 255));
            fetch_queue.push_back(it);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (fetch_queue.size() > 0 || s_valid || expected_state.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
